[rtl/lrsp_pkg.sv]
// ----------------------------------------------------------------------------
// lrsp_pkg
// Types, codes and constants shared by the level record stream parser.
// ----------------------------------------------------------------------------
package lrsp_pkg;

    // Default length of the header that precedes the draw commands.
    localparam int HEADER_BYTES_DEFAULT = 32;

    // Depth of the result queue and the width of its pointers and fill count.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // Parser phases.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_OPCODE = 2'd1;
    localparam logic [1:0] PH_INCMD  = 2'd2;
    localparam logic [1:0] PH_TRAIL  = 2'd3;

    // Record kinds.
    localparam logic [1:0] REC_HEADER = 2'd0;
    localparam logic [1:0] REC_DRAW   = 2'd1;
    localparam logic [1:0] REC_DONE   = 2'd2;
    localparam logic [1:0] REC_ERROR  = 2'd3;

    // Draw kinds, taken from the top two opcode bits.
    localparam logic [1:0] DRAW_SINGLE = 2'd0;
    localparam logic [1:0] DRAW_LINE   = 2'd1;
    localparam logic [1:0] DRAW_FILLED = 2'd2;
    localparam logic [1:0] DRAW_RECT   = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_SHORT    = 2'd1;
    localparam logic [1:0] ERR_INCMD    = 2'd2;
    localparam logic [1:0] ERR_TRAILING = 2'd3;

    localparam logic [7:0] TERMINATOR = 8'hff;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [4:0] header_index;
        logic [7:0] header_value;
        logic [1:0] draw_kind;
        logic [5:0] object_code;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] extra_a;
        logic [7:0] extra_b;
        logic [7:0] extra_c;
        logic [1:0] error_code;
        logic       run_end;
    } record_t;

    // Number of operand bytes that follow an opcode of the given draw kind.
    function automatic logic [2:0] operands_needed(input logic [1:0] kind);
        logic [2:0] need;
        case (kind)
            DRAW_SINGLE: need = 3'd2;
            DRAW_LINE:   need = 3'd4;
            DRAW_FILLED: need = 3'd5;
            DRAW_RECT:   need = 3'd4;
            default:     need = 3'd4;
        endcase
        return need;
    endfunction

endpackage

[rtl/level_record_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// level_record_stream_parser_unit
// Frames a byte stream of level definitions into header and draw records.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of a level definition per transfer
// (data_byte, with final_byte marking its last byte) under in_valid and
// in_stall. The output channel carries one record per transfer under
// out_valid and out_stall, with all record fields as separate ports.
// Each accepted byte is parsed in the cycle of its transfer and yields zero,
// one or two records, which are pushed into a four-entry result queue and
// reach the output in order from the queue's front.
// A byte can be accepted every cycle while the queue has room for two
// records, so the sustained rate is one byte per cycle whenever each byte
// gives at most one record and out_stall stays low; a byte that gives two
// records needs an output transfer for each. The queue depth sets how many
// stalled output cycles are absorbed before in_stall rises.
// Reset clears the parser to the start of a header and empties the queue.
// While out_stall is high the front record holds steady on the outputs.
// ----------------------------------------------------------------------------
module level_record_stream_parser_unit #(
    parameter int HEADER_BYTES = lrsp_pkg::HEADER_BYTES_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] record_kind,
    output logic [4:0] header_index,
    output logic [7:0] header_value,
    output logic [1:0] draw_kind,
    output logic [5:0] object_code,
    output logic [7:0] pos_x,
    output logic [7:0] pos_y,
    output logic [7:0] extra_a,
    output logic [7:0] extra_b,
    output logic [7:0] extra_c,
    output logic [1:0] error_code,
    output logic       run_end
);
    import lrsp_pkg::*;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [5:0] pos_reg;
    logic [5:0] pos_next;
    logic [7:0] opcode_reg;
    logic [7:0] opcode_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic [7:0] opnd_reg [4];
    logic       opnd_we;

    record_t    queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic       in_xfer;
    logic       out_xfer;
    record_t    rec0;
    record_t    rec1;
    record_t    err_rec;
    record_t    front;
    logic [1:0] push_n;
    logic [5:0] pos_plus;
    logic [2:0] cnt_plus;
    logic [1:0] kind;
    logic [7:0] opnd_view [4];

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    // Room for two records is needed before a byte is taken.
    assign in_stall  = (count_reg > QCNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);

    assign kind     = opcode_reg[7:6];
    assign pos_plus = pos_reg + 6'd1;
    assign cnt_plus = cnt_reg + 3'd1;

    // Operand bytes as they stand after this byte is stored.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            opnd_view[i] = (cnt_reg == 3'(i)) ? data_byte : opnd_reg[i];
        end
    end

    always_comb
    begin
        rec0        = '0;
        rec1        = '0;
        err_rec     = '0;
        push_n      = 2'd0;
        opnd_we     = 1'b0;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        opcode_next = opcode_reg;
        cnt_next    = cnt_reg;
        err_rec.record_kind = REC_ERROR;
        err_rec.error_code  = ERR_NONE;

        case (phase_reg)
            PH_HEADER:
            begin
                rec0.record_kind  = REC_HEADER;
                rec0.header_index = pos_reg[4:0];
                rec0.header_value = data_byte;
                push_n   = 2'd1;
                pos_next = pos_plus;
                if ((pos_plus >= 6'(HEADER_BYTES)) || (pos_plus == 6'd0))
                begin
                    phase_next = PH_OPCODE;
                end
                err_rec.error_code = ERR_SHORT;
            end
            PH_OPCODE:
            begin
                if (data_byte == TERMINATOR)
                begin
                    if (final_byte)
                    begin
                        rec0.record_kind = REC_DONE;
                        push_n = 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_TRAIL;
                    end
                end
                else if (!final_byte)
                begin
                    opcode_next = data_byte;
                    cnt_next    = 3'd0;
                    phase_next  = PH_INCMD;
                end
                err_rec.error_code = ERR_INCMD;
            end
            PH_INCMD:
            begin
                opnd_we  = !cnt_reg[2];
                cnt_next = cnt_plus;
                if (cnt_plus >= operands_needed(kind))
                begin
                    rec0.record_kind = REC_DRAW;
                    rec0.draw_kind   = kind;
                    rec0.object_code = opcode_reg[5:0];
                    rec0.pos_x       = opnd_view[0];
                    rec0.pos_y       = opnd_view[1];
                    if (kind != DRAW_SINGLE)
                    begin
                        rec0.extra_a = opnd_view[2];
                        rec0.extra_b = opnd_view[3];
                    end
                    if (kind == DRAW_FILLED)
                    begin
                        rec0.extra_c = data_byte;
                    end
                    push_n     = 2'd1;
                    cnt_next   = 3'd0;
                    phase_next = PH_OPCODE;
                end
                err_rec.error_code = ERR_INCMD;
            end
            default:
            begin
                err_rec.error_code = ERR_TRAILING;
            end
        endcase

        // The final byte always restarts the parser at the header. An error
        // record follows unless a clean terminator ended the definition.
        if (final_byte)
        begin
            if (!((phase_reg == PH_OPCODE) && (data_byte == TERMINATOR)))
            begin
                if (push_n == 2'd0)
                begin
                    rec0 = err_rec;
                end
                else
                begin
                    rec1 = err_rec;
                end
                push_n = push_n + 2'd1;
            end
            phase_next  = PH_HEADER;
            pos_next    = 6'd0;
            opcode_next = 8'd0;
            cnt_next    = 3'd0;
        end

        if (push_n == 2'd1)
        begin
            rec0.run_end = 1'b1;
        end
        else if (push_n == 2'd2)
        begin
            rec1.run_end = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 6'd0;
            opcode_reg <= 8'd0;
            cnt_reg    <= 3'd0;
        end
        else if (in_xfer)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            opcode_reg <= opcode_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && opnd_we)
        begin
            opnd_reg[cnt_reg[1:0]] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (push_n != 2'd0)
            begin
                queue_reg[wr_ptr_reg] <= rec0;
            end
            if (push_n == 2'd2)
            begin
                queue_reg[wr_ptr_reg + QPTR_W'(1)] <= rec1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            end
            if (out_xfer)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + (in_xfer ? QCNT_W'(push_n) : '0)
                         - QCNT_W'(out_xfer);
        end
    end

    assign front        = queue_reg[rd_ptr_reg];
    assign record_kind  = front.record_kind;
    assign header_index = front.header_index;
    assign header_value = front.header_value;
    assign draw_kind    = front.draw_kind;
    assign object_code  = front.object_code;
    assign pos_x        = front.pos_x;
    assign pos_y        = front.pos_y;
    assign extra_a      = front.extra_a;
    assign extra_b      = front.extra_b;
    assign extra_c      = front.extra_c;
    assign error_code   = front.error_code;
    assign run_end      = front.run_end;

    // The queue never holds more records than it has entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A record without run_end always has its partner already queued.
    a_pair_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !run_end) |-> (count_reg >= QCNT_W'(2)))
        else $error("first of a record pair without its partner");

    // With no transfer on either side the fill count holds.
    a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_xfer && !out_xfer) |=> $stable(count_reg))
        else $error("queue count moved without a transfer");

    // The byte marked final always leaves the parser at the start of a header.
    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && final_byte) |=> ((phase_reg == PH_HEADER) && (pos_reg == 6'd0)))
        else $error("parser did not restart after the final byte");

endmodule
